FILE: hdl/urpf_pkg.sv
// ----------------------------------------------------------------------------
// urpf_pkg
// shared constants and the result word type of the udp receive port filter
// ----------------------------------------------------------------------------
package urpf_pkg;

  localparam int unsigned MAX_PAYLOAD = 1500;
  localparam int unsigned LEN_W       = $clog2(MAX_PAYLOAD + 1);
  localparam logic [15:0] HDR_BYTES   = 16'd8;
  localparam logic [15:0] POS_MAX     = 16'hFFFF;
  localparam logic [15:0] MAX_LEN16   = 16'(MAX_PAYLOAD);

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        has_data;
    logic        last_of_payload;
    logic [10:0] payload_length;
    logic [31:0] sender_addr;
    logic [15:0] sender_port;
  } result_t;

endpackage

FILE: hdl/urpf_deframer.sv
// ----------------------------------------------------------------------------
// urpf_deframer
// header capture, port check, length clamp and payload tagging, one byte a cycle while take is high
// ----------------------------------------------------------------------------
module urpf_deframer import urpf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        take,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic [15:0] datagram_len,
  input  logic [31:0] source_addr,
  output logic        res_valid,
  output result_t     res
);

  logic [15:0]      listen_port;
  logic [15:0]      byte_position;
  logic [7:0]       header_high_byte;
  logic [15:0]      captured_src_port;
  logic [31:0]      captured_src_addr;
  logic [LEN_W-1:0] effective_payload_len;
  logic             port_accepted;

  logic [15:0]      pos;
  logic [15:0]      hdr_word;
  logic [15:0]      ulen;
  logic [15:0]      plen;
  logic [15:0]      eff16;
  logic [15:0]      k;
  logic             in_header;
  logic [LEN_W-1:0] plen_clamped;

  assign pos       = first_byte ? 16'd0 : byte_position;
  assign hdr_word  = {header_high_byte, data_byte};
  assign in_header = (pos < HDR_BYTES);
  assign eff16     = 16'(effective_payload_len);
  assign k         = pos - HDR_BYTES;

  always_comb begin
    ulen = hdr_word;
    if (hdr_word < HDR_BYTES || hdr_word > datagram_len) begin
      ulen = datagram_len;
    end
    plen = (ulen >= HDR_BYTES) ? (ulen - HDR_BYTES) : 16'd0;
    if (plen > MAX_LEN16) begin
      plen = MAX_LEN16;
    end
    plen_clamped = LEN_W'(plen);
  end

  always_comb begin
    res_valid                = 1'b0;
    res.payload_byte         = 8'd0;
    res.has_data             = 1'b0;
    res.last_of_payload      = 1'b1;
    res.payload_length       = 11'd0;
    res.sender_addr          = captured_src_addr;
    res.sender_port          = captured_src_port;
    if (in_header) begin
      if (pos[2:0] == 3'd7 && port_accepted && effective_payload_len == '0) begin
        res_valid = take;
      end
    end else if (port_accepted && k < eff16) begin
      res_valid           = take;
      res.payload_byte    = data_byte;
      res.has_data        = 1'b1;
      res.last_of_payload = ((k + 16'd1) == eff16);
      res.payload_length  = eff16[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      listen_port           <= 16'd0;
      byte_position         <= 16'd0;
      header_high_byte      <= 8'd0;
      captured_src_port     <= 16'd0;
      captured_src_addr     <= 32'd0;
      effective_payload_len <= '0;
      port_accepted         <= 1'b0;
    end else begin
      if (cfg_write) begin
        listen_port <= cfg_data;
      end
      if (take) begin
        byte_position <= (pos != POS_MAX) ? pos + 16'd1 : pos;
        if (in_header) begin
          case (pos[2:0])
            3'd0: begin
              captured_src_addr     <= source_addr;
              captured_src_port     <= {data_byte, 8'd0};
              port_accepted         <= 1'b0;
              effective_payload_len <= '0;
            end
            3'd1: begin
              captured_src_port <= {captured_src_port[15:8], data_byte};
            end
            3'd2, 3'd4: begin
              header_high_byte <= data_byte;
            end
            3'd3: begin
              port_accepted <= (datagram_len >= HDR_BYTES) && (hdr_word == listen_port);
            end
            3'd5: begin
              effective_payload_len <= plen_clamped;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

endmodule

FILE: hdl/urpf_out_buf.sv
// ----------------------------------------------------------------------------
// urpf_out_buf
// result register with a skid stage so upstream stall is driven from a flop
// ----------------------------------------------------------------------------
module urpf_out_buf import urpf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    res_valid,
  input  result_t res,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_word
);

  logic    skid_valid;
  result_t skid_word;
  logic    drain;

  assign full  = skid_valid;
  assign drain = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (!out_valid) begin
      out_valid <= res_valid;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_word <= skid_valid ? skid_word : res;
    end else if (!out_valid) begin
      out_word <= res;
    end else if (res_valid) begin
      skid_word <= res;
    end
  end

endmodule

FILE: hdl/udp_receive_port_filter_unit.sv
// ----------------------------------------------------------------------------
// udp_receive_port_filter_unit
// udp datagram deframer with a single listened port, payload streamed out
//
//   channel  signals                                   direction
//   in       in_valid, in_stall, data_byte,            datagram bytes in
//            first_byte, datagram_len, source_addr
//   out      out_valid, out_stall, payload_byte, ...   payload words out
//   cfg      cfg_valid, cfg_ready, cfg_data            listened port write
//
// one byte per cycle while in_stall is low; each result is registered
// in a two-word output buffer, so bytes flow on while one result waits
// in_stall rises only when both output stages hold a word
// rst is synchronous and clears the header state and the listened port
// ----------------------------------------------------------------------------
module udp_receive_port_filter_unit import urpf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic [15:0] datagram_len,
  input  logic [31:0] source_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  payload_byte,
  output logic        has_data,
  output logic        last_of_payload,
  output logic [10:0] payload_length,
  output logic [31:0] sender_addr,
  output logic [15:0] sender_port
);

  logic    take;
  logic    res_valid;
  result_t res;
  result_t out_word;

  assign cfg_ready = 1'b1;
  assign take      = in_valid && !in_stall;

  urpf_deframer u_deframer (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .take         (take),
    .data_byte    (data_byte),
    .first_byte   (first_byte),
    .datagram_len (datagram_len),
    .source_addr  (source_addr),
    .res_valid    (res_valid),
    .res          (res)
  );

  urpf_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign payload_byte    = out_word.payload_byte;
  assign has_data        = out_word.has_data;
  assign last_of_payload = out_word.last_of_payload;
  assign payload_length  = out_word.payload_length;
  assign sender_addr     = out_word.sender_addr;
  assign sender_port     = out_word.sender_port;

endmodule
